// File: rtl/hra_pkg.sv
// shared constants, types and structs of the stereo hermite resampler
package hra_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 19;
  localparam int PH_W      = FRAC_BITS + 3;
  localparam int MU_W      = FRAC_BITS + 1;
  localparam int TAPS      = 4;
  localparam int CH        = 2;
  localparam int CH_LEFT   = 0;
  localparam int CH_RIGHT  = 1;
  localparam int MAX_OUT   = 8;
  localparam int CNT_W     = $clog2(MAX_OUT);
  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = $clog2(QDEPTH);

  localparam logic [PH_W-1:0] ONE_PH    = PH_W'(1) << FRAC_BITS;
  localparam logic [PH_W-1:0] PHASE_MAX = ONE_PH << 2;

  typedef logic [CH-1:0][TAPS-1:0][SAMPLE_W-1:0] hist_t;
  typedef logic [CH-1:0][SAMPLE_W-1:0] pair_t;

  typedef struct packed {
    logic [MU_W-1:0] mu;
    hist_t           hist;
    logic            last;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  typedef struct packed {
    logic            busy;
    logic [PH_W-1:0] phase;
  } front_stat_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QPTR_W:0]   count;
  } queue_stat_t;

endpackage

// File: rtl/hra_front.sv
// front end: takes input pairs, runs the phase and issues interpolation jobs
module hra_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [hra_pkg::STEP_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [hra_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [hra_pkg::SAMPLE_W-1:0] right_in,
  output hra_pkg::push_t                    push,
  input  hra_pkg::queue_stat_t              qstat,
  output hra_pkg::front_stat_t              stat
);

  localparam int CMP_W = (hra_pkg::STEP_W > hra_pkg::PH_W) ? hra_pkg::STEP_W : hra_pkg::PH_W;
  localparam logic [CMP_W-1:0] STEP_MIN = CMP_W'(hra_pkg::ONE_PH) >> 3;
  localparam logic [CMP_W-1:0] STEP_MAX = CMP_W'(hra_pkg::ONE_PH) << 2;

  logic [hra_pkg::STEP_W-1:0] rate_step;
  logic [hra_pkg::PH_W-1:0]   phase, phase_next;
  hra_pkg::hist_t             hist, hist_next, shifted;
  hra_pkg::pair_t             sample;
  logic                       busy, busy_next;
  logic [hra_pkg::CNT_W-1:0]  cnt, cnt_next;

  logic [CMP_W-1:0]           step_wide, step_sat;
  logic [hra_pkg::PH_W-1:0]   step, phase_sum, phase_fin;
  logic                       in_range, do_push, last, finish, accept;

  always_comb begin
    step_wide = CMP_W'(rate_step);
    if (step_wide < STEP_MIN) begin
      step_sat = STEP_MIN;
    end else if (step_wide > STEP_MAX) begin
      step_sat = STEP_MAX;
    end else begin
      step_sat = step_wide;
    end
    step      = hra_pkg::PH_W'(step_sat);
    phase_sum = phase + step;
    in_range  = phase <= hra_pkg::ONE_PH;
    do_push   = busy && in_range && !qstat.full;
    last      = (phase_sum > hra_pkg::ONE_PH) ||
                (cnt == hra_pkg::CNT_W'(hra_pkg::MAX_OUT - 1));
    finish    = busy && (!in_range || (do_push && last));
    in_stall  = busy && !finish;
    accept    = in_valid && !in_stall;

    for (int c = 0; c < hra_pkg::CH; c++) begin
      for (int t = 0; t < hra_pkg::TAPS - 1; t++) begin
        shifted[c][t] = hist[c][t+1];
      end
      shifted[c][hra_pkg::TAPS-1] = sample[c];
    end

    if (in_range) begin
      phase_fin = (phase_sum > hra_pkg::ONE_PH) ? phase_sum - hra_pkg::ONE_PH : '0;
    end else begin
      phase_fin = phase - hra_pkg::ONE_PH;
    end

    if (finish) begin
      phase_next = phase_fin;
    end else if (do_push) begin
      phase_next = phase_sum;
    end else begin
      phase_next = phase;
    end

    hist_next = finish ? shifted : hist;

    if (accept || finish) begin
      cnt_next = '0;
    end else if (do_push) begin
      cnt_next = cnt + hra_pkg::CNT_W'(1);
    end else begin
      cnt_next = cnt;
    end

    if (accept) begin
      busy_next = 1'b1;
    end else if (finish) begin
      busy_next = 1'b0;
    end else begin
      busy_next = busy;
    end

    push.valid    = do_push;
    push.job.mu   = phase[hra_pkg::MU_W-1:0];
    push.job.hist = hist;
    push.job.last = last;
    stat.busy     = busy;
    stat.phase    = phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_step <= hra_pkg::STEP_W'(hra_pkg::ONE_PH);
      phase     <= hra_pkg::ONE_PH;
      hist      <= '0;
      busy      <= 1'b0;
      cnt       <= '0;
    end else begin
      if (cfg_we) begin
        rate_step <= cfg_wdata;
      end
      phase <= phase_next;
      hist  <= hist_next;
      busy  <= busy_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample[hra_pkg::CH_LEFT]  <= left_in;
      sample[hra_pkg::CH_RIGHT] <= right_in;
    end
  end

endmodule

// File: rtl/hra_queue.sv
// short job queue between the front end and the interpolation pipeline
module hra_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  hra_pkg::push_t       push,
  input  logic                 pop,
  output hra_pkg::job_t        head,
  output hra_pkg::queue_stat_t qstat
);

  hra_pkg::job_t                mem [hra_pkg::QDEPTH];
  logic [hra_pkg::QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [hra_pkg::QPTR_W:0]     count;

  always_comb begin
    head        = mem[rd_ptr];
    qstat.count = count;
    qstat.empty = count == '0;
    qstat.full  = count == (hra_pkg::QPTR_W+1)'(hra_pkg::QDEPTH);
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      mem[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + hra_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + hra_pkg::QPTR_W'(1);
      end
      case ({push.valid, pop})
        2'b10:   count <= count + (hra_pkg::QPTR_W+1)'(1);
        2'b01:   count <= count - (hra_pkg::QPTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/hra_back.sv
// back end: pipelined cubic hermite interpolation, rounding and saturation
module hra_back (
  input  logic                                clk,
  input  logic                                rst,
  input  hra_pkg::job_t                       head,
  input  hra_pkg::queue_stat_t                qstat,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hra_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [hra_pkg::SAMPLE_W-1:0] right_out,
  output logic                                last_of_run
);

  localparam int F    = hra_pkg::FRAC_BITS;
  localparam int MU_W = hra_pkg::MU_W;
  localparam int SQ_W = 2 * MU_W;
  localparam int WT_W = F + 4;
  localparam int D_W  = hra_pkg::SAMPLE_W + 1;
  localparam int P_W  = WT_W + D_W;
  localparam int S_W  = P_W + 2;
  localparam int CH   = hra_pkg::CH;
  localparam int TAPS = hra_pkg::TAPS;

  localparam logic signed [WT_W-1:0] ONE_W  = WT_W'(hra_pkg::ONE_PH);
  localparam logic signed [S_W-1:0]  BIAS   = (S_W'(1) << (F + 1)) - S_W'(1);
  localparam logic signed [S_W-1:0]  SAT_HI = (S_W'(1) << (hra_pkg::SAMPLE_W - 1)) - S_W'(1);
  localparam logic signed [S_W-1:0]  SAT_LO = ~SAT_HI;

  logic advance;
  logic v1, v2, v3, v4, v5;

  // stage 1 / 2: powers of mu
  logic [SQ_W-1:0] sq1, sq2;
  logic [MU_W-1:0] s1_mu, s1_mu2, s2_mu2, s2_mu3, s2_mu_hold;
  hra_pkg::hist_t  s1_hist, s2_hist;
  logic            s1_last, s2_last, s3_last, s4_last, s5_last;

  // stage 3: weights and differences
  logic signed [WT_W-1:0] m, m2, m3;
  logic signed [WT_W-1:0] a_c [TAPS];
  logic signed [WT_W-1:0] s3_a [TAPS];
  logic signed [hra_pkg::SAMPLE_W-1:0] s3_h1 [CH];
  logic signed [hra_pkg::SAMPLE_W-1:0] s3_h2 [CH];
  logic signed [D_W-1:0] s3_d0 [CH];
  logic signed [D_W-1:0] s3_d1 [CH];

  // stage 4 / 5: products and sum
  logic signed [P_W-1:0] s4_p [CH][TAPS];
  logic signed [S_W-1:0] s5_sum [CH];

  // output stage
  logic signed [S_W-1:0] bias [CH];
  logic signed [S_W-1:0] adj [CH];
  logic signed [S_W-1:0] q [CH];
  logic signed [hra_pkg::SAMPLE_W-1:0] res [CH];

  always_comb begin
    advance = !out_valid || !out_stall;
    pop     = advance && !qstat.empty;
    sq1     = SQ_W'(head.mu) * SQ_W'(head.mu);
    sq2     = SQ_W'(s1_mu2) * SQ_W'(s1_mu);
  end

  always_comb begin
    m2 = $signed(WT_W'(s2_mu2));
    m3 = $signed(WT_W'(s2_mu3));
    m  = $signed(WT_W'(s2_mu_hold));
    a_c[0] = (m3 <<< 1) - (m2 + (m2 <<< 1)) + ONE_W;
    a_c[1] = m3 - (m2 <<< 1) + m;
    a_c[2] = m3 - m2;
    a_c[3] = (m2 + (m2 <<< 1)) - (m3 <<< 1);
  end

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      bias[c] = s5_sum[c][S_W-1] ? BIAS : '0;
      adj[c]  = s5_sum[c] + bias[c];
      q[c]    = adj[c] >>> (F + 1);
      if (q[c] > SAT_HI) begin
        res[c] = SAT_HI[hra_pkg::SAMPLE_W-1:0];
      end else if (q[c] < SAT_LO) begin
        res[c] = SAT_LO[hra_pkg::SAMPLE_W-1:0];
      end else begin
        res[c] = q[c][hra_pkg::SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= !qstat.empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_mu      <= head.mu;
      s1_mu2     <= sq1[F +: MU_W];
      s1_hist    <= head.hist;
      s1_last    <= head.last;

      s2_mu_hold <= s1_mu;
      s2_mu2     <= s1_mu2;
      s2_mu3     <= sq2[F +: MU_W];
      s2_hist    <= s1_hist;
      s2_last    <= s1_last;

      for (int t = 0; t < TAPS; t++) begin
        s3_a[t] <= a_c[t];
      end
      for (int c = 0; c < CH; c++) begin
        s3_h1[c] <= $signed(s2_hist[c][1]);
        s3_h2[c] <= $signed(s2_hist[c][2]);
        s3_d0[c] <= D_W'($signed(s2_hist[c][2])) - D_W'($signed(s2_hist[c][0]));
        s3_d1[c] <= D_W'($signed(s2_hist[c][3])) - D_W'($signed(s2_hist[c][1]));
      end
      s3_last <= s2_last;

      for (int c = 0; c < CH; c++) begin
        s4_p[c][0] <= P_W'(s3_a[0]) * P_W'(s3_h1[c]);
        s4_p[c][1] <= P_W'(s3_a[1]) * P_W'(s3_d0[c]);
        s4_p[c][2] <= P_W'(s3_a[2]) * P_W'(s3_d1[c]);
        s4_p[c][3] <= P_W'(s3_a[3]) * P_W'(s3_h2[c]);
      end
      s4_last <= s3_last;

      for (int c = 0; c < CH; c++) begin
        s5_sum[c] <= ((S_W'(s4_p[c][0]) <<< 1) + S_W'(s4_p[c][1])) +
                     (S_W'(s4_p[c][2]) + (S_W'(s4_p[c][3]) <<< 1));
      end
      s5_last <= s4_last;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && v5) begin
      left_out    <= res[hra_pkg::CH_LEFT];
      right_out   <= res[hra_pkg::CH_RIGHT];
      last_of_run <= s5_last;
    end
  end

endmodule

// File: rtl/hermite_audio_resampler.sv
// top level of the stereo cubic hermite resampler
//
// input channel: one stereo pair per request (left_in, right_in), taken at a
// clock edge with in_valid high and in_stall low. each request causes zero to
// eight output requests (left_out, right_out, last_of_run), taken at an edge
// with out_valid high and out_stall low; last_of_run marks the final output
// caused by an input, and an input that causes no output gives no request.
// rate_step (unsigned, 16 fraction bits, used saturated to 1/8 .. 4.0) is
// written through cfg_we / cfg_wdata; the user must do so only while the
// block is idle, and the block itself does not enforce this. the front end
// issues one output job per cycle while the job queue is not full, and
// takes the next input in the cycle it issues the last job for the current
// one, or when it finds an input causes none. an accepted input reaches the
// outputs through the job queue and the five-stage interpolation pipeline.
// when out_stall is high with out_valid set the pipeline holds, the job queue fills and the
// front end then raises in_stall; nothing is lost or repeated.
// synchronous reset clears history to zero, the phase and rate_step to 1.0,
// and empties the queue and pipeline.
module hermite_audio_resampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [hra_pkg::STEP_W-1:0]          cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [hra_pkg::SAMPLE_W-1:0] left_in,
  input  logic signed [hra_pkg::SAMPLE_W-1:0] right_in,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [hra_pkg::SAMPLE_W-1:0] left_out,
  output logic signed [hra_pkg::SAMPLE_W-1:0] right_out,
  output logic                                last_of_run
);

  hra_pkg::push_t       push;
  hra_pkg::job_t        head;
  hra_pkg::queue_stat_t qstat;
  hra_pkg::front_stat_t fstat;
  logic                 pop;

  hra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .left_in   (left_in),
    .right_in  (right_in),
    .push      (push),
    .qstat     (qstat),
    .stat      (fstat)
  );

  hra_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .qstat (qstat)
  );

  hra_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .qstat       (qstat),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .left_out    (left_out),
    .right_out   (right_out),
    .last_of_run (last_of_run)
  );

`ifndef NO_ASSERTIONS
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push.valid && qstat.full))
    else $error("job issued into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    qstat.count <= (hra_pkg::QPTR_W+1)'(hra_pkg::QDEPTH))
    else $error("queue count beyond depth");

  a_phase_bound: assert property (@(posedge clk) disable iff (rst)
    fstat.phase <= hra_pkg::PHASE_MAX)
    else $error("phase beyond 4.0");

  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    (!fstat.busy) |-> !in_stall)
    else $error("input stalled while front end idle");
`endif

endmodule

// File: tb/tb_top.sv
// self-checking testbench for the stereo cubic hermite resampler
`timescale 1ns / 1ps

module tb_top;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 24;
  localparam int RANDOM_PER_STEP = 43;
  localparam logic [hra_pkg::STEP_W-1:0] STEP_MIN = hra_pkg::ONE_PH >> 3;
  localparam logic [hra_pkg::STEP_W-1:0] STEP_MAX = hra_pkg::ONE_PH << 2;

  typedef logic signed [hra_pkg::SAMPLE_W-1:0] taps_t [hra_pkg::TAPS];

  typedef struct {
    logic signed [hra_pkg::SAMPLE_W-1:0] left;
    logic signed [hra_pkg::SAMPLE_W-1:0] right;
  } stereo_pair_t;

  typedef struct {
    logic signed [hra_pkg::SAMPLE_W-1:0] left;
    logic signed [hra_pkg::SAMPLE_W-1:0] right;
    logic                                last;
  } out_pair_t;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_we;
  logic [hra_pkg::STEP_W-1:0]          cfg_wdata;
  logic                                in_valid;
  logic                                in_stall;
  logic signed [hra_pkg::SAMPLE_W-1:0] left_in;
  logic signed [hra_pkg::SAMPLE_W-1:0] right_in;
  logic                                out_valid;
  logic                                out_stall;
  logic signed [hra_pkg::SAMPLE_W-1:0] left_out;
  logic signed [hra_pkg::SAMPLE_W-1:0] right_out;
  logic                                last_of_run;

  stereo_pair_t pending_pairs[$];
  out_pair_t    pairs_due[$];
  stereo_pair_t next_pair;

  taps_t                      left_hist;
  taps_t                      right_hist;
  logic [hra_pkg::PH_W-1:0]   model_phase;
  logic [hra_pkg::STEP_W-1:0] rate_cfg;

  bit calm;
  int errors;
  int cycles;
  int requests_in;
  int pairs_checked;
  int quiet_inputs;
  int steps_used;

  hermite_audio_resampler DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out),
    .last_of_run(last_of_run)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic signed [hra_pkg::SAMPLE_W-1:0] hermite_sample(
      logic [hra_pkg::PH_W-1:0] mu, taps_t h);
    longint m, m2, m3, one, a0, a1, a2, a3, h0, h1, h2, h3, s, q;
    m = longint'(mu);
    one = longint'(1) << hra_pkg::FRAC_BITS;
    m2 = (m * m) >>> hra_pkg::FRAC_BITS;
    m3 = (m2 * m) >>> hra_pkg::FRAC_BITS;
    a0 = 2 * m3 - 3 * m2 + one;
    a1 = m3 - 2 * m2 + m;
    a2 = m3 - m2;
    a3 = 3 * m2 - 2 * m3;
    h0 = h[0];
    h1 = h[1];
    h2 = h[2];
    h3 = h[3];
    s = 2 * a0 * h1 + a1 * (h2 - h0) + a2 * (h3 - h1) + 2 * a3 * h2;
    q = s / (longint'(1) << (hra_pkg::FRAC_BITS + 1));
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[hra_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic resample_pair(logic signed [hra_pkg::SAMPLE_W-1:0] l,
                               logic signed [hra_pkg::SAMPLE_W-1:0] r);
    logic [hra_pkg::STEP_W-1:0] step;
    out_pair_t p;
    int n;
    step = rate_cfg;
    if (step < STEP_MIN) step = STEP_MIN;
    if (step > STEP_MAX) step = STEP_MAX;
    n = 0;
    while (model_phase <= hra_pkg::ONE_PH && n < hra_pkg::MAX_OUT) begin
      p.left = hermite_sample(model_phase, left_hist);
      p.right = hermite_sample(model_phase, right_hist);
      n++;
      model_phase = model_phase + step;
      p.last = !(model_phase <= hra_pkg::ONE_PH && n < hra_pkg::MAX_OUT);
      pairs_due.push_back(p);
    end
    if (n == 0) quiet_inputs++;
    for (int i = 0; i < hra_pkg::TAPS - 1; i++) begin
      left_hist[i] = left_hist[i+1];
      right_hist[i] = right_hist[i+1];
    end
    left_hist[hra_pkg::TAPS-1] = l;
    right_hist[hra_pkg::TAPS-1] = r;
    model_phase = (model_phase > hra_pkg::ONE_PH) ? model_phase - hra_pkg::ONE_PH : '0;
  endtask

  task automatic check_pair();
    out_pair_t want;
    if (pairs_due.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected output: left %0d right %0d last %0b",
                 left_out, right_out, last_of_run);
    end else begin
      want = pairs_due.pop_front();
      pairs_checked++;
      if (left_out !== want.left || right_out !== want.right || last_of_run !== want.last) begin
        errors++;
        if (errors <= 10)
          $display("mismatch at output %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                   pairs_checked, want.left, want.right, want.last,
                   left_out, right_out, last_of_run);
      end
    end
  endtask

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      left_in <= '0;
      right_in <= '0;
      model_phase = hra_pkg::ONE_PH;
      for (int i = 0; i < hra_pkg::TAPS; i++) begin
        left_hist[i] = '0;
        right_hist[i] = '0;
      end
    end else begin
      if (in_valid && !in_stall) begin
        resample_pair(left_in, right_in);
        requests_in++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_pairs.size() > 0 && (calm || $urandom_range(99) >= 38)) begin
          next_pair = pending_pairs.pop_front();
          in_valid <= 1'b1;
          left_in <= next_pair.left;
          right_in <= next_pair.right;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) check_pair();
      out_stall <= !calm && ($urandom_range(99) < 38);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic push_pair(logic signed [hra_pkg::SAMPLE_W-1:0] l,
                           logic signed [hra_pkg::SAMPLE_W-1:0] r);
    stereo_pair_t p;
    p.left = l;
    p.right = r;
    pending_pairs.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_pairs.size() > 0 || in_valid || pairs_due.size() > 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [hra_pkg::STEP_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_cfg = v;
    steps_used++;
  endtask

  task automatic queue_random(int count);
    int wl, wr;
    logic signed [hra_pkg::SAMPLE_W-1:0] l, r;
    wl = 0;
    wr = 0;
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          wl = wl + int'($urandom_range(4095)) - 2048;
          wr = wr + int'($urandom_range(4095)) - 2048;
          l = wl[hra_pkg::SAMPLE_W-1:0];
          r = wr[hra_pkg::SAMPLE_W-1:0];
          wl = l;
          wr = r;
        end
        4, 5, 6, 7: begin
          l = hra_pkg::SAMPLE_W'($urandom);
          r = hra_pkg::SAMPLE_W'($urandom);
        end
        default: begin
          l = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          r = $urandom_range(1) ? 16'sh0000 : 16'shffff;
          if ($urandom_range(1)) r = ~l;
        end
      endcase
      push_pair(l, r);
    end
  endtask

  logic [hra_pkg::STEP_W-1:0] step_plan[7];

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    calm = 1'b0;
    rate_cfg = hra_pkg::ONE_PH;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes at unity step, then overshoot and clamping at the finest step
    push_pair(16'sh0000, 16'sh0000);
    push_pair(16'sh7fff, 16'sh8000);
    push_pair(16'sh8000, 16'sh7fff);
    push_pair(16'sh0001, 16'shffff);
    push_pair(16'shffff, 16'sh0001);
    wait_drained();
    write_step(STEP_MIN);
    for (int k = 0; k < 4; k++) begin
      push_pair(16'sh7fff, 16'sh8000);
      push_pair(16'sh8000, 16'sh7fff);
    end
    push_pair(16'sh7fff, 16'sh7fff);
    push_pair(16'sh7fff, 16'sh7fff);
    push_pair(16'sh8000, 16'sh8000);
    push_pair(16'sh8000, 16'sh8000);
    push_pair(16'sh0000, 16'sh0000);
    push_pair(16'sh0000, 16'sh0000);
    wait_drained();

    // random runs over a spread of step settings, out-of-range ones included
    step_plan[0] = STEP_MAX;
    step_plan[1] = '0;
    step_plan[2] = '1;
    step_plan[3] = hra_pkg::STEP_W'($urandom_range(STEP_MAX, STEP_MIN));
    step_plan[4] = hra_pkg::STEP_W'(98304);
    step_plan[5] = hra_pkg::STEP_W'($urandom);
    step_plan[6] = hra_pkg::ONE_PH;
    for (int s = 0; s < 7; s++) begin
      write_step(step_plan[s]);
      calm = (s == 3);
      queue_random(RANDOM_PER_STEP);
      wait_drained();
    end
    calm = 1'b0;

    if (pairs_due.size() > 0) begin
      $display("%0d expected outputs never arrived", pairs_due.size());
    end
    $display("%0d stereo requests in (%0d with no output), %0d output pairs checked",
             requests_in, quiet_inputs, pairs_checked);
    $display("%0d step settings written, %0d failures", steps_used, errors);
    if (errors == 0 && pairs_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/hra_pkg.sv
rtl/hra_front.sv
rtl/hra_queue.sv
rtl/hra_back.sv
rtl/hermite_audio_resampler.sv
tb/tb_top.sv
